[hw/rtl/fvn_pkg.sv]
`timescale 1ns / 1ps

package fvn_pkg;

    localparam logic [31:0] HASH_X    = 32'd374761393;
    localparam logic [31:0] HASH_Y    = 32'd668265263;
    localparam logic [31:0] HASH_S    = 32'd1274126177;
    localparam logic [31:0] HASH_MIX  = 32'd1103515245;
    localparam logic [31:0] SEED_STEP = 32'd7919;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    localparam int OCT_LAT = 11;
    localparam int QUO_W   = 17;

    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_OCTAVE = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef logic [16:0] q16_t;

endpackage

[hw/rtl/fvn_octave.sv]
`timescale 1ns / 1ps

module fvn_octave #(
    parameter int FRAC_BITS = 16,
    parameter int OCT       = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [31:0]   x_coord,
    input  logic [31:0]   y_coord,
    input  logic [31:0]   seed,
    input  logic          ridge,
    output fvn_pkg::q16_t value
);
    import fvn_pkg::*;

    logic [63:0] xs, ys;
    logic [FRAC_BITS+15:0] fxw, fyw;
    logic [31:0] seed_oct;

    // s1
    logic [31:0] ix_reg, iy_reg, sc_reg;
    logic [15:0] tx_reg, ty_reg;
    // s2
    logic [31:0] xa0_reg, xa1_reg, yb0_reg, yb1_reg, sc2_reg;
    logic [31:0] ttx_reg, tty_reg;
    logic [15:0] tx2_reg, ty2_reg;
    // s3
    logic [31:0] h_reg [4];
    logic [15:0] cx_reg, cy_reg;
    logic [20:0] px_reg, py_reg;
    logic [37:0] pwx, pwy;
    // s4
    logic [31:0] m_reg [4];
    logic [31:0] g [4];
    logic [16:0] fx_reg, fy_reg;
    logic [36:0] fpx, fpy;
    // s5
    logic [16:0] n_reg [4];
    logic [31:0] h2 [4];
    logic [31:0] mag [4];
    logic [16:0] fx5_reg, fy5_reg;
    // s6
    logic [33:0] p_reg [4];
    logic [16:0] fy6_reg;
    // s7
    logic [16:0] l0_reg, l1_reg, fy7_reg;
    logic [34:0] s0, s1;
    // s8
    logic [33:0] q0_reg, q1_reg;
    // s9
    logic [16:0] v_reg;
    logic [34:0] qs;
    // s10
    logic [17:0] v2;
    logic [16:0] dd, rr;
    logic [33:0] rsq_reg;
    logic [16:0] v10_reg;
    // s11
    logic [16:0] out_reg;

    assign xs = {{32{x_coord[31]}}, x_coord} << OCT;
    assign ys = {{32{y_coord[31]}}, y_coord} << OCT;
    assign fxw = {xs[FRAC_BITS-1:0], 16'h0000} >> FRAC_BITS;
    assign fyw = {ys[FRAC_BITS-1:0], 16'h0000} >> FRAC_BITS;
    assign seed_oct = seed + 32'(OCT) * SEED_STEP;

    assign pwx = (38'd10 << 32) + 38'(ttx_reg) * 38'd6 - (38'(tx2_reg) << 16) * 38'd15;
    assign pwy = (38'd10 << 32) + 38'(tty_reg) * 38'd6 - (38'(ty2_reg) << 16) * 38'd15;
    assign fpx = 37'(cx_reg) * 37'(px_reg);
    assign fpy = 37'(cy_reg) * 37'(py_reg);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            g[k]   = h_reg[k] ^ 32'($signed(h_reg[k]) >>> 13);
            h2[k]  = m_reg[k] ^ 32'($signed(m_reg[k]) >>> 16);
            mag[k] = h2[k][31] ? (32'd0 - h2[k]) : h2[k];
        end
    end

    assign s0 = 35'(p_reg[0]) + 35'(p_reg[1]);
    assign s1 = 35'(p_reg[2]) + 35'(p_reg[3]);
    assign qs = 35'(q0_reg) + 35'(q1_reg);

    assign v2 = {v_reg, 1'b0};
    assign dd = (v2 >= 18'(Q16_ONE)) ? 17'(v2 - 18'(Q16_ONE)) : 17'(18'(Q16_ONE) - v2);
    assign rr = Q16_ONE - dd;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix_reg <= xs[FRAC_BITS +: 32];
            iy_reg <= ys[FRAC_BITS +: 32];
            tx_reg <= fxw[15:0];
            ty_reg <= fyw[15:0];
            sc_reg <= seed_oct * HASH_S;

            xa0_reg <= ix_reg * HASH_X;
            xa1_reg <= (ix_reg + 32'd1) * HASH_X;
            yb0_reg <= iy_reg * HASH_Y;
            yb1_reg <= (iy_reg + 32'd1) * HASH_Y;
            sc2_reg <= sc_reg;
            ttx_reg <= 32'(tx_reg) * 32'(tx_reg);
            tty_reg <= 32'(ty_reg) * 32'(ty_reg);
            tx2_reg <= tx_reg;
            ty2_reg <= ty_reg;

            h_reg[0] <= xa0_reg + yb0_reg + sc2_reg;
            h_reg[1] <= xa1_reg + yb0_reg + sc2_reg;
            h_reg[2] <= xa0_reg + yb1_reg + sc2_reg;
            h_reg[3] <= xa1_reg + yb1_reg + sc2_reg;
            cx_reg <= 16'((32'(ttx_reg[31:16]) * 32'(tx2_reg)) >> 16);
            cy_reg <= 16'((32'(tty_reg[31:16]) * 32'(ty2_reg)) >> 16);
            px_reg <= pwx[36:16];
            py_reg <= pwy[36:16];

            for (int k = 0; k < 4; k++)
                m_reg[k] <= g[k] * HASH_MIX;
            fx_reg <= (fpx[36:16] > 21'(Q16_ONE)) ? Q16_ONE : fpx[32:16];
            fy_reg <= (fpy[36:16] > 21'(Q16_ONE)) ? Q16_ONE : fpy[32:16];

            for (int k = 0; k < 4; k++)
                n_reg[k] <= mag[k][31:15];
            fx5_reg <= fx_reg;
            fy5_reg <= fy_reg;

            p_reg[0] <= 34'(n_reg[0]) * 34'(Q16_ONE - fx5_reg);
            p_reg[1] <= 34'(n_reg[1]) * 34'(fx5_reg);
            p_reg[2] <= 34'(n_reg[2]) * 34'(Q16_ONE - fx5_reg);
            p_reg[3] <= 34'(n_reg[3]) * 34'(fx5_reg);
            fy6_reg  <= fy5_reg;

            l0_reg  <= s0[32:16];
            l1_reg  <= s1[32:16];
            fy7_reg <= fy6_reg;

            q0_reg <= 34'(l0_reg) * 34'(Q16_ONE - fy7_reg);
            q1_reg <= 34'(l1_reg) * 34'(fy7_reg);

            v_reg <= qs[32:16];

            rsq_reg <= 34'(rr) * 34'(rr);
            v10_reg <= v_reg;

            out_reg <= ridge ? rsq_reg[32:16] : v10_reg;
        end
    end

    assign value = out_reg;

endmodule

[hw/rtl/fvn_div.sv]
`timescale 1ns / 1ps

module fvn_div #(
    parameter int DIV_W = 8
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_W+16:0]    dividend,
    input  logic [DIV_W-1:0]     divisor,
    output fvn_pkg::q16_t        quotient
);
    import fvn_pkg::*;

    logic [DIV_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DIV_W-1:0] dvs_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_step
            logic [DIV_W-1:0] rem_in, dvs_in;
            logic [QUO_W-1:0] low_in, quo_in;
            logic [DIV_W:0]   trial;
            logic             ge;
            if (k == 0)
            begin : g_first
                assign rem_in = dividend[DIV_W+16:QUO_W];
                assign low_in = dividend[QUO_W-1:0];
                assign quo_in = '0;
                assign dvs_in = divisor;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
            end
            assign trial = {rem_in, low_in[QUO_W-1]};
            assign ge    = trial >= {1'b0, dvs_in};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? DIV_W'(trial - {1'b0, dvs_in}) : DIV_W'(trial);
                    low_reg[k] <= {low_in[QUO_W-2:0], 1'b0};
                    quo_reg[k] <= {quo_in[QUO_W-2:0], ge};
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[QUO_W-1];

endmodule

[hw/rtl/fractal_value_noise_2d.sv]
`timescale 1ns / 1ps

// channel  dir  handshake                 payload
// s_*      in   s_tvalid/s_tready         s_tdata[31:0] x_coord, [63:32] y_coord
// m_*      out  m_tvalid/m_tready         m_tdata[16:0] noise_value
// apb      in   psel/penable/pwrite       paddr 0 seed, 4 octave_count, 8 noise_mode
//
// One beat per cycle sustained unless the output stalls; the path is the input
// register, 11-stage octave lanes running all octaves side by side, weight and sum
// stages, then a 17-stage restoring divider by 2^n-1, last stage the output register.
// Reset clears the valid pipeline and the registers to seed 0, 4 octaves, plain.
// A stalled output freezes the whole pipeline; no beat is dropped or repeated.

module fractal_value_noise_2d #(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_coord, y_coord
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // noise_value, zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fvn_pkg::*;

    localparam int N_W   = $clog2(MAX_OCTAVES + 1);
    localparam int SUM_W = MAX_OCTAVES + QUO_W;
    localparam int TOT   = 1 + OCT_LAT + 2 + QUO_W;

    logic [31:0] seed_reg;
    logic [3:0]  oct_reg;
    logic        mode_reg;
    logic        wr;

    logic [TOT-1:0] vld_reg, vld_next;
    logic           en;
    logic [31:0]    x_reg, y_reg;
    q16_t           lane_v [MAX_OCTAVES];
    logic [SUM_W-1:0] wv_reg [MAX_OCTAVES];
    logic [SUM_W-1:0] wv_next [MAX_OCTAVES];
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [N_W-1:0]   n_eff;
    logic [MAX_OCTAVES-1:0] dvs;
    q16_t quo;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            oct_reg  <= 4'd4;
            mode_reg <= 1'b0;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_SEED:   seed_reg <= pwdata;
                REG_OCTAVE: oct_reg  <= pwdata[3:0];
                REG_MODE:   mode_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SEED:   prdata = seed_reg;
            REG_OCTAVE: prdata = {28'd0, oct_reg};
            REG_MODE:   prdata = {31'd0, mode_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        if (oct_reg == 4'd0)
            n_eff = N_W'(1);
        else if (5'(oct_reg) > 5'(MAX_OCTAVES))
            n_eff = N_W'(MAX_OCTAVES);
        else
            n_eff = N_W'(oct_reg);
    end

    assign dvs = MAX_OCTAVES'((17'd1 << n_eff) - 17'd1);

    assign m_tvalid = vld_reg[TOT-1];
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[TOT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= s_tdata[31:0];
            y_reg <= s_tdata[63:32];
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_OCTAVES; i++)
        begin : g_lane
            fvn_octave #(
                .FRAC_BITS (FRAC_BITS),
                .OCT       (i)
            ) u_oct (
                .clk     (clk),
                .en      (en),
                .x_coord (x_reg),
                .y_coord (y_reg),
                .seed    (seed_reg),
                .ridge   (mode_reg),
                .value   (lane_v[i])
            );
        end
    endgenerate

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < MAX_OCTAVES; k++)
        begin
            if (k < int'(n_eff))
                wv_next[k] = SUM_W'(lane_v[k]) << (int'(n_eff) - 1 - k);
            else
                wv_next[k] = '0;
            sum_next = sum_next + wv_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < MAX_OCTAVES; k++)
                wv_reg[k] <= wv_next[k];
            sum_reg <= sum_next;
        end
    end

    fvn_div #(
        .DIV_W (MAX_OCTAVES)
    ) u_div (
        .clk      (clk),
        .en       (en),
        .dividend (sum_reg),
        .divisor  (dvs),
        .quotient (quo)
    );

    assign m_tdata = {7'd0, quo};

`ifndef NO_ASSERTIONS
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:0] <= 17'd65536))
        else $error("noise value above one");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat lost at entry");
`endif

endmodule
